### hw/rtl/integer_set_operation_filter_macros.svh
// ----------------------------------------------------------------------------
// Integer set operation filter assertion macros
// Concurrent assertion shorthands used by the set filter top level.
// ----------------------------------------------------------------------------
`ifndef INTEGER_SET_OPERATION_FILTER_MACROS_SVH
`define INTEGER_SET_OPERATION_FILTER_MACROS_SVH

// same-cycle implication
`define ISOF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("set filter assertion failed");

// next-cycle implication
`define ISOF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("set filter assertion failed");

`endif

### hw/rtl/isof_pkg.sv
// ----------------------------------------------------------------------------
// Integer set operation filter package
// Shared types, field widths and codes of the set filter.
// ----------------------------------------------------------------------------
package isof_pkg;

   localparam int VALUE_W     = 32;
   localparam int ACTION_W    = 2;
   localparam int OP_W        = 2;
   localparam int SET_COUNT_W = 7;

   // rsp_tdata layout
   localparam int RSP_SEL_BIT     = VALUE_W;
   localparam int RSP_PRESENT_BIT = VALUE_W + 1;
   localparam int RSP_COUNT_LSB   = VALUE_W + 2;
   localparam int RSP_OVF_BIT     = RSP_COUNT_LSB + SET_COUNT_W;
   localparam int RSP_USED_W      = RSP_OVF_BIT + 1;
   localparam int RSP_TDATA_W     = 48;
   localparam int RSP_PAD_W       = RSP_TDATA_W - RSP_USED_W;

   localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_OPERATE = 2'd2;

   localparam logic [OP_W-1:0] OP_UNION     = 2'd0;
   localparam logic [OP_W-1:0] OP_DIFF      = 2'd1;
   localparam logic [OP_W-1:0] OP_INTERSECT = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } seq_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] key;
      logic               hit;
   } token_type;

   typedef struct packed {
      logic               en;
      logic [VALUE_W-1:0] value;
   } cell_wr_type;

endpackage

### hw/rtl/isof_cell.sv
// ----------------------------------------------------------------------------
// Integer set operation filter cell
// Holds one stored element; compares the passing key and forwards the token.
// ----------------------------------------------------------------------------
module isof_cell (
   input  logic                  clock,
   input  isof_pkg::cell_wr_type wr,
   input  logic                  live,
   input  isof_pkg::token_type   up_tok,
   output isof_pkg::token_type   down_tok
);
   import isof_pkg::*;

   logic [VALUE_W-1:0] entry_ff, entry_in;
   token_type          tok_ff, tok_in;

   always_comb begin
      entry_in   = wr.en ? wr.value : entry_ff;
      tok_in.key = up_tok.key;
      tok_in.hit = up_tok.hit | (live && (entry_ff == up_tok.key));
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      tok_ff   <= tok_in;
   end

   assign down_tok = tok_ff;

endmodule

### hw/rtl/isof_seq.sv
// ----------------------------------------------------------------------------
// Integer set operation filter sequencer
// Takes a transaction, waits for the scan token, updates the set, responds.
// ----------------------------------------------------------------------------
module isof_seq #(
   parameter  int CAPACITY = 64,
   localparam int COUNT_W  = $clog2(CAPACITY + 1),
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [isof_pkg::ACTION_W-1:0]       req_action,
   input  logic [isof_pkg::VALUE_W-1:0]        req_value,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // echo_value, selected, was_present, set_count, overflow, zero pad
   output logic [isof_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic [isof_pkg::OP_W-1:0]           set_operation,
   output logic [isof_pkg::VALUE_W-1:0]        scan_key,
   input  logic                                scan_hit,
   output logic [COUNT_W-1:0]                  count,
   output isof_pkg::cell_wr_type               wr,
   output logic [IDX_W-1:0]                    wr_idx
);
   import isof_pkg::*;

   seq_state_type            state_ff, state_in;
   logic [COUNT_W-1:0]       step_ff, step_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [ACTION_W-1:0]      action_ff, action_in;
   logic [VALUE_W-1:0]       key_ff, key_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_sel_ff, rsp_sel_in;
   logic                     rsp_present_ff, rsp_present_in;
   logic [SET_COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                     done;
   logic                     out_free;
   logic                     present;
   logic [SET_COUNT_W+COUNT_W-1:0] count_wide;

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      count_in       = count_ff;
      action_in      = action_ff;
      key_in         = key_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_sel_in     = rsp_sel_ff;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      wr.en          = 1'b0;
      wr.value       = key_ff;
      wr_idx         = count_ff[IDX_W-1:0];
      req_tready     = (state_ff == ST_IDLE);

      done       = (step_ff == COUNT_W'(CAPACITY));
      out_free   = !rsp_valid_ff || rsp_tready;
      present    = (action_ff != ACT_CLEAR) && scan_hit;
      count_wide = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in = req_action;
               key_in    = req_value;
               step_in   = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!done) begin
               step_in = step_ff + COUNT_W'(1);
            end else if (out_free) begin
               rsp_sel_in = 1'b0;
               rsp_ovf_in = 1'b0;
               case (action_ff)
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_INSERT: begin
                     if (!present) begin
                        if (count_ff < COUNT_W'(CAPACITY)) begin
                           wr.en      = 1'b1;
                           count_in   = count_ff + COUNT_W'(1);
                           rsp_sel_in = 1'b1;
                        end else begin
                           rsp_ovf_in = 1'b1;
                        end
                     end
                  end
                  ACT_OPERATE: begin
                     case (set_operation) inside
                        OP_UNION, OP_DIFF: rsp_sel_in = !present;
                        OP_INTERSECT:      rsp_sel_in = present;
                        default:           rsp_sel_in = 1'b0;
                     endcase
                  end
                  default: ;
               endcase
               count_wide     = {{SET_COUNT_W{1'b0}}, count_in};
               rsp_count_in   = count_wide[SET_COUNT_W-1:0];
               rsp_value_in   = key_ff;
               rsp_present_in = present;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      action_ff      <= action_in;
      key_ff         <= key_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_sel_ff     <= rsp_sel_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign scan_key   = key_ff;
   assign count      = count_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ovf_ff, rsp_count_ff, rsp_present_ff,
                        rsp_sel_ff, rsp_value_ff};

endmodule

### hw/rtl/integer_set_operation_filter.sv
// ----------------------------------------------------------------------------
// Integer set operation filter
// Keeps a set of distinct signed 32-bit values and filters a streamed set.
// ----------------------------------------------------------------------------
// Input stream req_*: tdata carries the element, tuser the action (clear,
// insert if absent, apply set operation). Output stream rsp_*: one
// transaction per input transaction, carrying the echoed element, selected,
// was_present, the set size after the transaction and the overflow flag.
// csr_wr_en/csr_wr_data write the set operation (union, difference,
// intersection); write it only while the block is idle.
// Each transaction sends a search token down a chain of CAPACITY cells, one
// cell per cycle. rsp_tvalid rises once the token has left the last cell and
// the result is registered, and req_tready returns in the same cycle, so a
// new transaction is not taken while one is still in its scan.
// The result sits in an output register: a new transaction is accepted
// while it waits, and its scan holds at the chain end until the output
// register is taken. Reset empties the set, selects union and drops any
// transaction in flight; stored values are not cleared.
// ----------------------------------------------------------------------------
`include "integer_set_operation_filter_macros.svh"

module integer_set_operation_filter #(
   parameter int CAPACITY = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [isof_pkg::OP_W-1:0]        csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // element_value
   input  logic [isof_pkg::VALUE_W-1:0]     req_tdata,
   // action
   input  logic [isof_pkg::ACTION_W-1:0]    req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // echo_value, selected, was_present, set_count, overflow, zero pad
   output logic [isof_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import isof_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [OP_W-1:0]    set_operation_ff, set_operation_in;
   logic [VALUE_W-1:0] scan_key;
   logic [COUNT_W-1:0] set_count;
   cell_wr_type        wr;
   logic [IDX_W-1:0]   wr_idx;
   token_type          link [CAPACITY+1];
   cell_wr_type        cell_wr [CAPACITY];
   logic               cell_live [CAPACITY];

   always_comb begin
      set_operation_in = csr_wr_en ? csr_wr_data : set_operation_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_operation_ff <= OP_UNION;
      end else begin
         set_operation_ff <= set_operation_in;
      end
   end

   assign link[0].key = scan_key;
   assign link[0].hit = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_wr[i].en    = wr.en && (wr_idx == IDX_W'(i));
      assign cell_wr[i].value = wr.value;
      assign cell_live[i]     = (COUNT_W'(i) < set_count);

      isof_cell u_cell (
         .clock    (clock),
         .wr       (cell_wr[i]),
         .live     (cell_live[i]),
         .up_tok   (link[i]),
         .down_tok (link[i+1])
      );
   end

   isof_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_action    (req_tuser),
      .req_value     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .set_operation (set_operation_ff),
      .scan_key      (scan_key),
      .scan_hit      (link[CAPACITY].hit),
      .count         (set_count),
      .wr            (wr),
      .wr_idx        (wr_idx)
   );

   `ISOF_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `ISOF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, set_count <= COUNT_W'(CAPACITY))
   `ISOF_ASSERT_IMPL(a_overflow_only, clock, reset, rsp_tvalid && rsp_tdata[RSP_OVF_BIT], !rsp_tdata[RSP_SEL_BIT] && !rsp_tdata[RSP_PRESENT_BIT])

endmodule
